### rtl/core/dfsw_pkg.sv
// shared types, constants and the control program of the depth-first walk core
`default_nettype none
package dfsw_pkg;

  localparam int MAX_NODES = 32;
  localparam int IW = $clog2(MAX_NODES);
  localparam int VW = $clog2(MAX_NODES + 1);
  localparam int RW = 32;

  localparam logic [VW-1:0] NODE_COUNT_RST   = VW'(32);
  localparam logic [VW-1:0] START_VERTEX_RST = VW'(1);

  typedef enum logic {
    REG_NODE_COUNT   = 1'b0,
    REG_START_VERTEX = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ACT_LOAD_ROW = 1'b0,
    ACT_RUN      = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_INIT = 2'd1,
    S_PICK = 2'd2,
    S_LAST = 2'd3
  } step_e;

  typedef enum logic [1:0] {
    UOP_WAIT = 2'd0,
    UOP_INIT = 2'd1,
    UOP_PICK = 2'd2,
    UOP_EMIT_LAST = 2'd3
  } uop_e;

  typedef enum logic [1:0] {
    J_ALWAYS     = 2'd0,
    J_RUN        = 2'd1,
    J_BAD_START  = 2'd2,
    J_WALK_DONE  = 2'd3
  } jcond_e;

  typedef struct packed {
    uop_e   op;
    jcond_e jcond;
    step_e  jtarget;
    step_e  next;
  } ctrl_word_t;

  typedef struct packed {
    logic bad_start;
    logic walk_done;
  } dp_status_t;

  function automatic ctrl_word_t ucode_rom(input step_e step);
    ctrl_word_t w;
    unique case (step)
      S_IDLE:  w = '{op: UOP_WAIT,      jcond: J_RUN,       jtarget: S_INIT, next: S_IDLE};
      S_INIT:  w = '{op: UOP_INIT,      jcond: J_BAD_START, jtarget: S_IDLE, next: S_PICK};
      S_PICK:  w = '{op: UOP_PICK,      jcond: J_WALK_DONE, jtarget: S_LAST, next: S_PICK};
      S_LAST:  w = '{op: UOP_EMIT_LAST, jcond: J_ALWAYS,    jtarget: S_IDLE, next: S_IDLE};
      default: w = '{op: UOP_WAIT,      jcond: J_ALWAYS,    jtarget: S_IDLE, next: S_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

### rtl/core/dfsw_seq.sv
// step counter, control rom lookup and jump evaluation
`default_nettype none
module dfsw_seq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  run_req_i,
  input  dfsw_pkg::dp_status_t status_i,
  output dfsw_pkg::ctrl_word_t ctrl_o,
  output logic                 busy_o
);

  dfsw_pkg::step_e      step_q, step_d;
  dfsw_pkg::ctrl_word_t cw;
  logic                 take_jump;

  always_comb begin
    cw = dfsw_pkg::ucode_rom(step_q);
    ctrl_o = cw;
    busy_o = (step_q != dfsw_pkg::S_IDLE);
  end

  always_comb begin
    unique case (cw.jcond)
      dfsw_pkg::J_ALWAYS:    take_jump = 1'b1;
      dfsw_pkg::J_RUN:       take_jump = run_req_i;
      dfsw_pkg::J_BAD_START: take_jump = status_i.bad_start;
      dfsw_pkg::J_WALK_DONE: take_jump = status_i.walk_done;
      default:               take_jump = 1'b0;
    endcase
    step_d = take_jump ? cw.jtarget : cw.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= dfsw_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
`default_nettype wire

### rtl/core/dfsw_dp.sv
// datapath: adjacency rows, visit marks, parent store, neighbor pick and result register
`default_nettype none
module dfsw_dp (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  dfsw_pkg::ctrl_word_t           ctrl_i,
  input  wire                            load_req_i,
  input  wire  [dfsw_pkg::VW-1:0]        row_vertex_i,
  input  wire  [dfsw_pkg::RW-1:0]        row_bits_i,
  input  wire                            cfg_we_i,
  input  wire                            cfg_idx_i,
  input  wire  [dfsw_pkg::VW-1:0]        cfg_wdata_i,
  output dfsw_pkg::dp_status_t           status_o,
  output logic                           result_valid_o,
  output logic [dfsw_pkg::VW-1:0]        visited_vertex_o,
  output logic [dfsw_pkg::VW-1:0]        parent_vertex_o,
  output logic                           last_o
);

  localparam int VW = dfsw_pkg::VW;
  localparam int IW = dfsw_pkg::IW;
  localparam int MN = dfsw_pkg::MAX_NODES;

  logic [dfsw_pkg::RW-1:0] rows_q [MN];
  logic [VW-1:0]           parent_q [MN];
  logic [MN-1:0]           visited_q, visited_d;
  logic [VW-1:0]           node_count_q, start_vertex_q;
  logic [VW-1:0]           cur_q, cur_d;
  logic [VW-1:0]           pend_vtx_q, pend_vtx_d, pend_par_q, pend_par_d;
  logic                    res_valid_q, res_valid_d, res_last_d, res_last_q;
  logic [VW-1:0]           res_vtx_q, res_vtx_d, res_par_q, res_par_d;

  logic [VW-1:0]           n_eff, row_m1, cur_m1, start_m1, pick_vtx;
  logic [MN-1:0]           limit, cand;
  logic [IW-1:0]           pick_idx;
  logic                    has_cand, par_we;
  logic [IW-1:0]           par_widx;
  logic [VW-1:0]           par_wdata, cur_parent;
  logic                    row_ok;

  assign n_eff    = (node_count_q > VW'(MN)) ? VW'(MN) : node_count_q;
  assign row_m1   = row_vertex_i - VW'(1);
  assign cur_m1   = cur_q - VW'(1);
  assign start_m1 = start_vertex_q - VW'(1);
  assign row_ok   = (row_vertex_i != '0) && (row_vertex_i <= VW'(MN));

  always_comb begin
    for (int k = 0; k < MN; k++) begin
      limit[k] = (VW'(k) < n_eff);
    end
  end

  assign cand       = rows_q[cur_m1[IW-1:0]] & limit & ~visited_q;
  assign has_cand   = (cand != '0);
  assign cur_parent = parent_q[cur_m1[IW-1:0]];

  // lowest set bit wins
  always_comb begin
    pick_idx = '0;
    for (int k = MN - 1; k >= 0; k--) begin
      if (cand[k]) begin
        pick_idx = IW'(k);
      end
    end
  end
  assign pick_vtx = VW'(pick_idx) + VW'(1);

  assign status_o.bad_start = (start_vertex_q == '0) || (start_vertex_q > n_eff);
  assign status_o.walk_done = !has_cand && (cur_parent == '0);

  always_comb begin
    visited_d   = visited_q;
    cur_d       = cur_q;
    pend_vtx_d  = pend_vtx_q;
    pend_par_d  = pend_par_q;
    res_valid_d = 1'b0;
    res_last_d  = res_last_q;
    res_vtx_d   = res_vtx_q;
    res_par_d   = res_par_q;
    par_we      = 1'b0;
    par_widx    = '0;
    par_wdata   = '0;
    unique case (ctrl_i.op)
      dfsw_pkg::UOP_WAIT: begin
      end
      dfsw_pkg::UOP_INIT: begin
        visited_d  = '0;
        cur_d      = '0;
        if (!status_o.bad_start) begin
          visited_d[start_m1[IW-1:0]] = 1'b1;
          cur_d      = start_vertex_q;
          pend_vtx_d = start_vertex_q;
          pend_par_d = '0;
          par_we     = 1'b1;
          par_widx   = start_m1[IW-1:0];
          par_wdata  = '0;
        end
      end
      dfsw_pkg::UOP_PICK: begin
        if (has_cand) begin
          // the held vertex is not the final one: send it now
          visited_d[pick_idx] = 1'b1;
          par_we      = 1'b1;
          par_widx    = pick_idx;
          par_wdata   = cur_q;
          res_valid_d = 1'b1;
          res_last_d  = 1'b0;
          res_vtx_d   = pend_vtx_q;
          res_par_d   = pend_par_q;
          pend_vtx_d  = pick_vtx;
          pend_par_d  = cur_q;
          cur_d       = pick_vtx;
        end else begin
          cur_d = cur_parent;
        end
      end
      dfsw_pkg::UOP_EMIT_LAST: begin
        res_valid_d = 1'b1;
        res_last_d  = 1'b1;
        res_vtx_d   = pend_vtx_q;
        res_par_d   = pend_par_q;
        cur_d       = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q      <= '0;
      cur_q          <= '0;
      res_valid_q    <= 1'b0;
      node_count_q   <= dfsw_pkg::NODE_COUNT_RST;
      start_vertex_q <= dfsw_pkg::START_VERTEX_RST;
      for (int k = 0; k < MN; k++) begin
        parent_q[k] <= '0;
      end
    end else begin
      visited_q   <= visited_d;
      cur_q       <= cur_d;
      res_valid_q <= res_valid_d;
      if (par_we) begin
        parent_q[par_widx] <= par_wdata;
      end
      if (cfg_we_i) begin
        unique case (dfsw_pkg::reg_idx_e'(cfg_idx_i))
          dfsw_pkg::REG_NODE_COUNT:   node_count_q   <= cfg_wdata_i;
          dfsw_pkg::REG_START_VERTEX: start_vertex_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_vtx_q <= pend_vtx_d;
    pend_par_q <= pend_par_d;
    res_last_q <= res_last_d;
    res_vtx_q  <= res_vtx_d;
    res_par_q  <= res_par_d;
    if (load_req_i && row_ok) begin
      rows_q[row_m1[IW-1:0]] <= row_bits_i;
    end
  end

  assign result_valid_o   = res_valid_q;
  assign visited_vertex_o = res_vtx_q;
  assign parent_vertex_o  = res_par_q;
  assign last_o           = res_last_q;

endmodule
`default_nettype wire

### rtl/core/dfs_adjacency_matrix_walk_core.sv
// top level of the depth-first adjacency matrix walk core
// usage:
//   an item is taken on a rising edge with start high and busy low.
//   action_i low stores row_bits_i as the adjacency row of row_vertex_i
//   (bit k-1 means an edge to vertex k); it completes in that edge and busy
//   stays low. action_i high runs a depth-first walk from start_vertex over
//   vertices 1..node_count (capped at 32), lowest-numbered neighbor first.
//   each visited vertex comes out as one beat on visited_vertex_o and
//   parent_vertex_o with result_valid_o high for one cycle; the start vertex
//   has parent 0 and the final beat carries last_o. results cannot be held off.
//   a run: one setup step, then the pick loop, in which each step either
//   visits a new vertex or backtracks one level through the parent store,
//   then one step to send the final beat. each beat shows the cycle after
//   its step. a start vertex outside 1..node_count gives no beats and ends
//   the run after the setup step.
//   config writes (cfg_we_i, cfg_idx_i: 0 node_count, 1 start_vertex) take
//   effect at once and belong in idle time.
//   reset clears marks and parents and sets node_count 32, start_vertex 1;
//   adjacency rows hold nothing useful until written.
`default_nettype none
module dfs_adjacency_matrix_walk_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start,
  output logic                         busy,
  input  wire                          action_i,
  input  wire  [dfsw_pkg::VW-1:0]      row_vertex_i,
  input  wire  [dfsw_pkg::RW-1:0]      row_bits_i,
  input  wire                          cfg_we_i,
  input  wire                          cfg_idx_i,
  input  wire  [dfsw_pkg::VW-1:0]      cfg_wdata_i,
  output logic                         result_valid_o,
  output logic [dfsw_pkg::VW-1:0]      visited_vertex_o,
  output logic [dfsw_pkg::VW-1:0]      parent_vertex_o,
  output logic                         last_o
);

  dfsw_pkg::ctrl_word_t ctrl;
  dfsw_pkg::dp_status_t status;
  logic                 accept, run_req, load_req;

  assign accept   = start && !busy;
  assign run_req  = accept && (dfsw_pkg::action_e'(action_i) == dfsw_pkg::ACT_RUN);
  assign load_req = accept && (dfsw_pkg::action_e'(action_i) == dfsw_pkg::ACT_LOAD_ROW);

  dfsw_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .run_req_i (run_req),
    .status_i  (status),
    .ctrl_o    (ctrl),
    .busy_o    (busy)
  );

  dfsw_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .load_req_i       (load_req),
    .row_vertex_i     (row_vertex_i),
    .row_bits_i       (row_bits_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .status_o         (status),
    .result_valid_o   (result_valid_o),
    .visited_vertex_o (visited_vertex_o),
    .parent_vertex_o  (parent_vertex_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire
